### rtl/mrc_pkg.sv
`default_nettype none
package mrc_pkg;

    localparam int MaxWords = 32;
    localparam int WordAddrW = 5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FRAMING   = 2'd1;
    localparam logic [1:0] ST_CRC       = 2'd2;
    localparam logic [1:0] ST_EXCEPTION = 2'd3;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_MULTI  = 2'd2;

    localparam logic [2:0] REG_KIND     = 3'd0;
    localparam logic [2:0] REG_ADDRESS  = 3'd1;
    localparam logic [2:0] REG_FUNCTION = 3'd2;
    localparam logic [2:0] REG_COUNT    = 3'd3;
    localparam logic [2:0] REG_REGISTER = 3'd4;
    localparam logic [2:0] REG_VALUE    = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
    localparam logic [7:0]  FC_EXC_BIT      = 8'h80;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_frame;
    } mrc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  exc_code;
        logic [15:0] word_value;
        logic [5:0]  word_index;
        logic        last;
    } mrc_out_t;

    // Write request into the word store.
    typedef struct packed {
        logic                 en;
        logic [WordAddrW-1:0] addr;
        logic [15:0]          data;
    } mrc_wr_t;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/mrc_word_ram.sv
`default_nettype none
module mrc_word_ram
    import mrc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire mrc_wr_t              wr,
    input  wire logic [WordAddrW-1:0] rd_addr,
    output logic [15:0]               rd_data
);
    logic [15:0] mem [MaxWords];

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### rtl/modbus_rtu_response_checker.sv
`default_nettype none
// Modbus RTU response checker. Each input beat carries one received byte; the
// CRC-16 and header capture keep pace with the input, so bytes are accepted
// back to back while no frame is being reported. On the last byte the frame is
// judged combinationally, then the block emits one result beat, or for a good
// read one beat per register word, read from the internal word store (a fetch
// state covers the registered read, then the word is presented once the output
// is free), with one more state after the last word before input resumes.
// No input beat is accepted until the last result beat of a frame has been
// taken. The word store needs no clearing: a good read only returns words
// written in the same frame.
module modbus_rtu_response_checker
    import mrc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire mrc_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output mrc_out_t      m_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam logic [1:0] S_RX    = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_WORDS = 2'd2;
    localparam logic [1:0] S_ONE   = 2'd3;

    logic [1:0]  kind_reg;
    logic [7:0]  exp_addr_reg, exp_func_reg, exp_cnt_reg;
    logic [15:0] exp_reg_reg, exp_val_reg;

    logic [15:0] crc_reg;
    logic [8:0]  len_reg;
    logic [7:0]  hb0_reg, hb1_reg, addr_reg, func_reg, pend_reg;
    logic [15:0] echo1_reg, echo2_reg;
    logic [1:0]  state_reg;
    logic [5:0]  idx_reg;
    logic [5:0]  nwords_reg;
    mrc_out_t    out_reg;
    logic        mv_reg;

    mrc_wr_t     wr;
    logic [WordAddrW-1:0] rd_addr;
    logic [15:0] rd_data;

    logic        s_fire, m_fire;
    logic [8:0]  p;
    logic [8:0]  d;
    logic [15:0] crc_next;
    logic [8:0]  len_next;
    logic [7:0]  addr_next, func_next;
    logic [15:0] echo1_next, echo2_next;
    logic [1:0]  st;
    logic [7:0]  exc, fc, bc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_RX) && !mv_reg;
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign m_valid   = mv_reg;
    assign m_data    = out_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= 2'd0; exp_addr_reg <= 8'd0; exp_func_reg <= 8'd3;
            exp_cnt_reg <= 8'd0; exp_reg_reg <= 16'd0; exp_val_reg <= 16'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_KIND:     kind_reg <= cfg_data[1:0];
                REG_ADDRESS:  exp_addr_reg <= cfg_data[7:0];
                REG_FUNCTION: exp_func_reg <= cfg_data[7:0];
                REG_COUNT:    exp_cnt_reg <= cfg_data[7:0];
                REG_REGISTER: exp_reg_reg <= cfg_data;
                REG_VALUE:    exp_val_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Release of the oldest held-back byte as payload.
    assign p = len_reg - 9'd2;
    assign d = len_reg - 9'd5;
    always_comb begin
        crc_next = crc_reg; addr_next = addr_reg; func_next = func_reg;
        echo1_next = echo1_reg; echo2_next = echo2_reg;
        wr = '0;
        if (len_reg >= 9'd2) begin
            crc_next = crc_byte(crc_reg, hb0_reg);
            case (p)
                9'd0: addr_next = hb0_reg;
                9'd1: func_next = hb0_reg;
                9'd2: echo1_next = {hb0_reg, 8'h00};
                9'd3: echo1_next = {echo1_reg[15:8], hb0_reg};
                9'd4: echo2_next = {hb0_reg, 8'h00};
                9'd5: echo2_next = {echo2_reg[15:8], hb0_reg};
                default: ;
            endcase
            if (s_fire && p >= 9'd3 && d[0] == 1'b1 && d[8:1] < 8'(MaxWords)) begin
                wr.en = 1'b1;
                wr.addr = d[WordAddrW:1];
                wr.data = {pend_reg, hb0_reg};
            end
        end
        len_next = (len_reg == 9'd511) ? len_reg : len_reg + 9'd1;
    end

    // Frame judgment on the updated state; the received CRC is the last two bytes.
    always_comb begin
        st = ST_OK; exc = 8'd0;
        fc = (kind_reg == KIND_READ) ? exp_func_reg :
             (kind_reg == KIND_SINGLE) ? FC_WRITE_SINGLE : FC_WRITE_MULTI;
        bc = echo1_next[15:8];
        if (len_next < 9'd5) st = ST_FRAMING;
        else if (kind_reg > KIND_MULTI) st = ST_FRAMING;
        else if ({s_data.rx_byte, hb1_reg} != crc_next) st = ST_CRC;
        else if (addr_next != exp_addr_reg) st = ST_FRAMING;
        else if (func_next == (fc | FC_EXC_BIT)) begin
            if (len_next != 9'd5) st = ST_FRAMING;
            else begin st = ST_EXCEPTION; exc = bc; end
        end else if (func_next != fc) st = ST_FRAMING;
        else if (kind_reg == KIND_READ) begin
            if (bc != {exp_cnt_reg[6:0], 1'b0}) st = ST_FRAMING;
            else if (len_next != 9'd5 + {1'b0, bc}) st = ST_FRAMING;
            else if (exp_cnt_reg > 8'(MaxWords)) st = ST_FRAMING;
        end else if (len_next != 9'd8) st = ST_FRAMING;
        else if (echo1_next != exp_reg_reg) st = ST_FRAMING;
        else if (kind_reg == KIND_SINGLE && echo2_next != exp_val_reg) st = ST_FRAMING;
        else if (kind_reg == KIND_MULTI && echo2_next != {8'h00, exp_cnt_reg})
            st = ST_FRAMING;
    end

    assign rd_addr = idx_reg[WordAddrW-1:0];

    mrc_word_ram u_ram (.aclk(aclk), .wr(wr), .rd_addr(rd_addr), .rd_data(rd_data));

    // Frame capture, sequencing and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT; len_reg <= 9'd0; hb0_reg <= 8'd0; hb1_reg <= 8'd0;
            addr_reg <= 8'd0; func_reg <= 8'd0; echo1_reg <= 16'd0; echo2_reg <= 16'd0;
            pend_reg <= 8'd0; state_reg <= S_RX; idx_reg <= 6'd0; nwords_reg <= 6'd0;
            mv_reg <= 1'b0; out_reg <= '0;
        end else begin
            if (m_fire) mv_reg <= 1'b0;
            unique case (state_reg)
                S_RX: begin
                    if (s_fire) begin
                        if (len_reg >= 9'd5 && d[0] == 1'b0) pend_reg <= hb0_reg;
                        crc_reg <= crc_next; addr_reg <= addr_next; func_reg <= func_next;
                        echo1_reg <= echo1_next; echo2_reg <= echo2_next;
                        hb0_reg <= hb1_reg; hb1_reg <= s_data.rx_byte; len_reg <= len_next;
                        if (s_data.end_of_frame) begin
                            crc_reg <= CRC_INIT; len_reg <= 9'd0; hb0_reg <= 8'd0;
                            hb1_reg <= 8'd0; addr_reg <= 8'd0; func_reg <= 8'd0;
                            echo1_reg <= 16'd0; echo2_reg <= 16'd0; pend_reg <= 8'd0;
                            idx_reg <= 6'd0;
                            nwords_reg <= exp_cnt_reg[5:0];
                            if (st == ST_OK && kind_reg == KIND_READ && exp_cnt_reg != 8'd0)
                                state_reg <= S_FETCH;
                            else begin
                                out_reg <= '{status: st, exc_code: exc,
                                             word_value: 16'd0, word_index: 6'd0,
                                             last: 1'b1};
                                mv_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_FETCH: state_reg <= S_WORDS;
                S_WORDS: begin
                    if (!mv_reg || m_fire) begin
                        out_reg <= '{status: ST_OK, exc_code: 8'd0,
                                     word_value: rd_data, word_index: idx_reg,
                                     last: (idx_reg + 6'd1 == nwords_reg)};
                        mv_reg <= 1'b1;
                        if (idx_reg + 6'd1 == nwords_reg) state_reg <= S_ONE;
                        else begin
                            idx_reg <= idx_reg + 6'd1;
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_ONE: state_reg <= S_RX;
                default: state_reg <= S_RX;
            endcase
        end
    end

    // Assertions.
    a_no_input_while_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_RX) |-> !s_ready) else $error("input taken while draining");
    a_word_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (out_reg.word_index < 6'(MaxWords))) else $error("word index range");
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && out_reg.last && state_reg == S_RX) |=> (len_reg == 9'd0))
        else $error("frame state not cleared");
endmodule
`default_nettype wire

### sim/modbus_response_scoreboard.sv
`timescale 1ns / 1ps
module modbus_response_scoreboard
    import mrc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire mrc_in_t     s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire mrc_out_t    m_data,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               error_count,
    output int               pending_count
);

    // Register shadow.
    logic [1:0]  kind_q;
    logic [7:0]  addr_q;
    logic [7:0]  func_q;
    logic [7:0]  count_q;
    logic [15:0] reg_q;
    logic [15:0] value_q;

    // Frame shadow.
    logic [15:0] crc_q;
    logic [8:0]  len_q;
    logic [7:0]  held_q [2];
    logic [7:0]  frame_addr_q;
    logic [7:0]  frame_func_q;
    logic [15:0] echo1_q;
    logic [15:0] echo2_q;
    logic [7:0]  high_q;
    logic [15:0] words_q [MaxWords];

    mrc_out_t expected_results [$];

    function automatic logic [15:0] crc_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ 16'hA001;
            else c = c >> 1;
        end
        return c;
    endfunction

    // Byte leaves the hold-back pair and becomes payload.
    task automatic take_payload(int p, logic [7:0] b);
        int d;
        crc_q = crc_next(crc_q, b);
        case (p)
            0: frame_addr_q = b;
            1: frame_func_q = b;
            2: echo1_q = {b, 8'h00};
            3: echo1_q[7:0] = b;
            4: echo2_q = {b, 8'h00};
            5: echo2_q[7:0] = b;
            default: ;
        endcase
        if (p >= 3) begin
            d = p - 3;
            if (d % 2 == 0) high_q = b;
            else if (d / 2 < MaxWords) words_q[d / 2] = {high_q, b};
        end
    endtask

    function automatic logic [1:0] judge_frame(output logic [7:0] exc);
        logic [7:0] fc;
        logic [7:0] bc;
        exc = 8'h00;
        if (len_q < 5) return ST_FRAMING;
        if (kind_q > KIND_MULTI) return ST_FRAMING;
        if ({held_q[1], held_q[0]} != crc_q) return ST_CRC;
        if (frame_addr_q != addr_q) return ST_FRAMING;
        if (kind_q == KIND_READ) fc = func_q;
        else if (kind_q == KIND_SINGLE) fc = FC_WRITE_SINGLE;
        else fc = FC_WRITE_MULTI;
        if (frame_func_q == (fc | FC_EXC_BIT)) begin
            if (len_q != 5) return ST_FRAMING;
            exc = echo1_q[15:8];
            return ST_EXCEPTION;
        end
        if (frame_func_q != fc) return ST_FRAMING;
        if (kind_q == KIND_READ) begin
            bc = echo1_q[15:8];
            if (bc != 8'(count_q * 2)) return ST_FRAMING;
            if (len_q != 9'(5 + bc)) return ST_FRAMING;
            if (count_q > MaxWords) return ST_FRAMING;
            return ST_OK;
        end
        if (len_q != 8) return ST_FRAMING;
        if (echo1_q != reg_q) return ST_FRAMING;
        if (kind_q == KIND_SINGLE && echo2_q != value_q) return ST_FRAMING;
        if (kind_q == KIND_MULTI && echo2_q != {8'h00, count_q}) return ST_FRAMING;
        return ST_OK;
    endfunction

    task automatic clear_frame();
        crc_q = CRC_INIT;
        len_q = '0;
        held_q[0] = '0;
        held_q[1] = '0;
        frame_addr_q = '0;
        frame_func_q = '0;
        echo1_q = '0;
        echo2_q = '0;
        high_q = '0;
    endtask

    task automatic predict_byte(mrc_in_t beat);
        logic [1:0] st;
        logic [7:0] exc;
        mrc_out_t r;
        if (len_q >= 2) take_payload(int'(len_q) - 2, held_q[0]);
        held_q[0] = held_q[1];
        held_q[1] = beat.rx_byte;
        if (len_q < 511) len_q++;
        if (beat.end_of_frame) begin
            st = judge_frame(exc);
            if (st == ST_OK && kind_q == KIND_READ && count_q > 0) begin
                for (int i = 0; i < count_q && i < MaxWords; i++) begin
                    r = '{ST_OK, 8'h00, words_q[i], 6'(i), (i + 1 == count_q)};
                    expected_results.push_back(r);
                end
            end else begin
                r = '{st, exc, 16'h0000, 6'd0, 1'b1};
                expected_results.push_back(r);
            end
            clear_frame();
        end
    endtask

    task automatic compare_result(mrc_out_t got);
        mrc_out_t want;
        if (expected_results.size() == 0) begin
            $error("result beat with nothing expected: %p", got);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
        end
        if (got.exc_code != want.exc_code) begin
            $error("exc_code: expected %0h, got %0h",
                want.exc_code, got.exc_code);
            error_count++;
        end
        if (got.word_value != want.word_value) begin
            $error("word_value: expected %0h, got %0h", want.word_value, got.word_value);
            error_count++;
        end
        if (got.word_index != want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
            error_count++;
        end
        if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            error_count++;
        end
    endtask

    // Watch the three channels at each rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            kind_q <= KIND_READ;
            addr_q <= '0;
            func_q <= 8'd3;
            count_q <= '0;
            reg_q <= '0;
            value_q <= '0;
            clear_frame();
            expected_results.delete();
            error_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KIND:     kind_q <= cfg_data[1:0];
                    REG_ADDRESS:  addr_q <= cfg_data[7:0];
                    REG_FUNCTION: func_q <= cfg_data[7:0];
                    REG_COUNT:    count_q <= cfg_data[7:0];
                    REG_REGISTER: reg_q <= cfg_data;
                    REG_VALUE:    value_q <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_byte(s_data);
            if (m_valid && m_ready) compare_result(m_data);
        end
        pending_count = expected_results.size();
    end

endmodule

### sim/tb_modbus_rtu_response_checker.sv
`timescale 1ns / 1ps
module tb_modbus_rtu_response_checker;
    import mrc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    mrc_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    mrc_out_t    m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_KIND;
    logic [15:0] cfg_data = '0;

    int error_count;
    int pending_count;
    int byte_total = 0;
    int idle_cycles = 0;
    bit calm_phase = 1'b0;
    bit hold_receiver = 1'b0;

    // Register settings of the current phase.
    logic [1:0]  kind;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [7:0]  count;
    logic [15:0] regaddr;
    logic [15:0] regval;

    localparam int IdleLimit = 20000;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    modbus_rtu_response_checker uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    modbus_response_scoreboard scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .error_count(error_count), .pending_count(pending_count)
    );

    // Receiver: random stall bursts, one long hold, none at the end.
    initial begin
        int n;
        @(negedge aclk);
        forever begin
            if (hold_receiver) begin
                m_ready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_receiver = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || hold_receiver)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("modbus_rtu_response_checker regression: fail");
            $finish;
        end
    end

    // Valid stays high after the beat; set_config drops it once all writes are done.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stops offering bytes and waits until every expected result has come.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic set_config(logic [1:0] k, logic [7:0] a, logic [7:0] f,
                              logic [7:0] c, logic [15:0] r, logic [15:0] v);
        drain();
        kind = k; slave = a; func = f; count = c; regaddr = r; regval = v;
        write_reg(REG_KIND, {14'd0, k});
        write_reg(REG_ADDRESS, {8'd0, a});
        write_reg(REG_FUNCTION, {8'd0, f});
        write_reg(REG_COUNT, {8'd0, c});
        write_reg(REG_REGISTER, r);
        write_reg(REG_VALUE, v);
        cfg_valid <= 1'b0;
    endtask

    // One byte beat, with an optional idle burst before it.
    task automatic send_byte(logic [7:0] b, logic eof);
        int n;
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_data <= '{b, eof};
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        byte_total++;
    endtask

    // Sends a frame body and appends a CRC, optionally corrupted.
    task automatic send_frame(logic [7:0] body [$], bit bad_crc);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (body[i]) crc = crc_byte(crc, body[i]);
        if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
        foreach (body[i]) send_byte(body[i], 1'b0);
        send_byte(crc[7:0], 1'b0);
        send_byte(crc[15:8], 1'b1);
    endtask

    task automatic send_raw(int len);
        for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
    endtask

    // Well-formed response for the current settings, with random flaws.
    task automatic send_response(int flaw);
        logic [7:0] body [$];
        logic [7:0] fc;
        int words;
        fc = (kind == KIND_READ) ? func : (kind == KIND_SINGLE) ? FC_WRITE_SINGLE
                                                                : FC_WRITE_MULTI;
        body.push_back(flaw == 1 ? slave ^ 8'h01 : slave);
        if (flaw == 2) begin
            body.push_back(fc | FC_EXC_BIT);
            body.push_back(8'($urandom));
            if ($urandom_range(0, 3) == 0) body.push_back(8'($urandom));
        end else begin
            body.push_back(flaw == 3 ? fc ^ 8'h20 : fc);
            if (kind == KIND_READ) begin
                words = count;
                body.push_back(8'(count * 2) ^ (flaw == 4 ? 8'h02 : 8'h00));
                for (int i = 0; i < 2 * words; i++) body.push_back(8'($urandom));
            end else begin
                body.push_back(regaddr[15:8]);
                body.push_back(regaddr[7:0] ^ (flaw == 4 ? 8'h01 : 8'h00));
                if (kind == KIND_SINGLE) begin
                    body.push_back(regval[15:8]);
                    body.push_back(regval[7:0]);
                end else begin
                    body.push_back(8'h00);
                    body.push_back(count);
                end
            end
            if (flaw == 6) body.push_back(8'($urandom));
        end
        send_frame(body, flaw == 5);
    endtask

    task automatic burst(int frames);
        int flaw;
        for (int i = 0; i < frames; i++) begin
            flaw = $urandom_range(0, 12);
            if (flaw == 7) send_raw($urandom_range(1, 6));
            else send_response(flaw > 7 ? 0 : flaw);
        end
    endtask

    initial begin
        logic [7:0] short_read [$];
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset settings, short frames, exception, extremes.
        kind = KIND_READ; slave = 8'h00; func = 8'd3; count = 8'd0;
        regaddr = 16'h0000; regval = 16'h0000;
        send_raw(1);
        send_raw(4);
        send_response(0);
        send_response(2);
        set_config(KIND_READ, 8'hFF, 8'hFF, 8'd2, 16'hFFFF, 16'hFFFF);
        send_response(0);
        send_response(5);
        send_response(1);
        set_config(KIND_READ, 8'h11, 8'h04, 8'd32, 16'h0000, 16'h0000);
        send_response(0);
        // A count of 128 wraps the byte count to zero, then fails the word limit.
        set_config(KIND_READ, 8'h11, 8'h03, 8'd128, 16'h0000, 16'h0000);
        short_read = {8'h11, 8'h03, 8'h00};
        send_frame(short_read, 1'b0);
        set_config(KIND_SINGLE, 8'h22, 8'h03, 8'd5, 16'h1234, 16'hABCD);
        send_response(0);
        send_response(4);
        set_config(KIND_MULTI, 8'h01, 8'h03, 8'd255, 16'h8001, 16'h0000);
        send_response(0);
        send_response(6);
        set_config(2'd3, 8'h01, 8'h03, 8'd1, 16'h0000, 16'h0000);
        send_response(0);

        // Random phases with random settings.
        for (int ph = 0; ph < 4; ph++) begin
            set_config(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom_range(1, 4)),
                8'($urandom_range(0, 6)), 16'($urandom), 16'($urandom));
            if (ph == 2) hold_receiver = 1'b1;
            burst(3);
        end

        // Sender pause until nothing is outstanding.
        drain();

        // Last part without idling.
        calm_phase = 1'b1;
        set_config(KIND_READ, 8'h05, 8'h03, 8'd3, 16'h0000, 16'h0000);
        burst(2);

        drain();
        if (error_count == 0)
            $display("modbus_rtu_response_checker regression: pass");
        else
            $display("modbus_rtu_response_checker regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/mrc_pkg.sv
rtl/mrc_word_ram.sv
rtl/modbus_rtu_response_checker.sv
sim/modbus_response_scoreboard.sv
sim/tb_modbus_rtu_response_checker.sv
